// File: rtl/core/rbfd_pkg.sv
// shared types and constants for the ring buffer frame deframer
// no dependencies; imported by rbfd_ctrl, rbfd_dp and ring_buffer_frame_deframer
package rbfd_pkg;

    localparam int BUF_AW       = 10;
    localparam int BUF_DEPTH    = 1 << BUF_AW;
    localparam int LEN_W        = BUF_AW + 1;
    localparam int MAX_VERDICTS = 64;
    localparam int NV_W         = $clog2(MAX_VERDICTS + 1);

    localparam logic [7:0]       HEADER_RST  = 8'h23;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(1024);
    localparam logic [7:0]       TIMEOUT_RST = 8'd100;
    localparam logic [LEN_W-1:0] MIN_FRAME   = LEN_W'(11);
    localparam logic [BUF_AW-1:0] HUNT_MIN   = BUF_AW'(10);

    // request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // register indexes
    localparam logic [1:0] REG_HEADER  = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_GOOD    = 3'd0;
    localparam logic [2:0] ST_BCC_ERR = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_OVF, S_HUNT, S_HDR0, S_HDR1, S_LEN0, S_LEN1,
        S_BCC_RD, S_BCC_ACC, S_FLD_RD, S_FLD_ACC, S_COMMIT, S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_WRITE, OP_LOAD_RD, OP_LOAD_OVF, OP_TICK_START, OP_HDR0,
        OP_HI, OP_SKIP1, OP_LOCK, OP_WAIT_INC, OP_BCC_START, OP_BCC_ACC,
        OP_BCC_END, OP_TIMEOUT, OP_FLD, OP_COMMIT, OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        RA_INPUT, RA_CONST, RA_COUNT
    } rd_sel_t;

    typedef struct packed {
        op_t               op;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic [BUF_AW-1:0] rd_off;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic size_le10;
        logic locked;
        logic complete;
        logic wait_lt;
        logic hdr_match;
        logic len_ok;
        logic off_last;
        logic off_fld_end;
        logic held_valid;
        logic n_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [BUF_AW-1:0] start;
        logic [LEN_W-1:0] length;
        logic [7:0]       cmd;
        logic [31:0]      total;
        logic [7:0]       seq;
    } verdict_t;

endpackage

// File: rtl/core/rbfd_ctrl.sv
// controller state machine for the frame deframer
// depends on rbfd_pkg; drives rbfd_dp through cmd_t, reads stat_t
module rbfd_ctrl
    import rbfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_BYTE: state_next = stat.full ? S_OVF : S_IDLE;
                        REQ_TICK: state_next = S_HUNT;
                        REQ_READ: state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ, S_OVF:
                if (stat.out_free) state_next = S_IDLE;
            S_HUNT:
            begin
                if (!stat.locked)
                    state_next = stat.size_le10 ? S_FINISH : S_HDR0;
                else if (stat.complete)
                    state_next = S_BCC_RD;
                else if (stat.wait_lt)
                    state_next = S_FINISH;
                else
                    state_next = S_FLD_RD;
            end
            S_HDR0:    state_next = S_HDR1;
            S_HDR1:    state_next = stat.hdr_match ? S_LEN0 : S_HUNT;
            S_LEN0:    state_next = S_LEN1;
            S_LEN1:    state_next = S_HUNT;
            S_BCC_RD:  state_next = S_BCC_ACC;
            S_BCC_ACC: state_next = stat.off_last ? S_FLD_RD : S_BCC_RD;
            S_FLD_RD:  state_next = S_FLD_ACC;
            S_FLD_ACC: state_next = stat.off_fld_end ? S_COMMIT : S_FLD_RD;
            S_COMMIT:
            begin
                if (!stat.held_valid || stat.out_free)
                    state_next = stat.n_last ? S_FINISH : S_HUNT;
            end
            S_FINISH:
            begin
                if (!stat.held_valid || stat.out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.op     = OP_NONE;
        cmd.rd_en  = 1'b0;
        cmd.rd_sel = RA_CONST;
        cmd.rd_off = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_BYTE: if (!stat.full) cmd.op = OP_WRITE;
                        REQ_TICK: cmd.op = OP_TICK_START;
                        REQ_READ:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_INPUT;
                        end
                        default:  cmd.op = OP_NONE;
                    endcase
                end
            end
            S_READ: if (stat.out_free) cmd.op = OP_LOAD_RD;
            S_OVF:  if (stat.out_free) cmd.op = OP_LOAD_OVF;
            S_HUNT:
            begin
                if (!stat.locked)
                begin
                    cmd.rd_en  = !stat.size_le10;
                    cmd.rd_off = BUF_AW'(0);
                end
                else if (stat.complete)
                    cmd.op = OP_BCC_START;
                else if (stat.wait_lt)
                    cmd.op = OP_WAIT_INC;
                else
                    cmd.op = OP_TIMEOUT;
            end
            S_HDR0:
            begin
                cmd.op     = OP_HDR0;
                cmd.rd_en  = 1'b1;
                cmd.rd_off = BUF_AW'(1);
            end
            S_HDR1:
            begin
                if (stat.hdr_match)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_off = BUF_AW'(8);
                end
                else
                    cmd.op = OP_SKIP1;
            end
            S_LEN0:
            begin
                cmd.op     = OP_HI;
                cmd.rd_en  = 1'b1;
                cmd.rd_off = BUF_AW'(9);
            end
            S_LEN1:    cmd.op = stat.len_ok ? OP_LOCK : OP_SKIP1;
            S_BCC_RD, S_FLD_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_COUNT;
            end
            S_BCC_ACC: cmd.op = stat.off_last ? OP_BCC_END : OP_BCC_ACC;
            S_FLD_ACC: cmd.op = OP_FLD;
            S_COMMIT:
                if (!stat.held_valid || stat.out_free) cmd.op = OP_COMMIT;
            S_FINISH:
                if (stat.held_valid && stat.out_free) cmd.op = OP_FLUSH;
            default:   cmd.op = OP_NONE;
        endcase
    end

    // the check walk is entered only from the hunt state or from its own accumulate step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BCC_RD) |-> $past(state_reg == S_HUNT || state_reg == S_BCC_ACC))
        else $error("check walk entered from wrong state");

    // a tick always ends through the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg == S_HUNT || state_reg == S_COMMIT
            || state_reg == S_HDR1 || state_reg == S_LEN1)) |-> 1'b0)
        else $error("tick left without flush");

    // the held verdict is never dropped on the way back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && state_next == S_IDLE && stat.held_valid)
            |-> (cmd.op == OP_FLUSH))
        else $error("held verdict lost");

endmodule

// File: rtl/core/rbfd_dp.sv
// datapath: ring memory, pointers, hunt registers, verdict and output registers
// depends on rbfd_pkg; controlled by rbfd_ctrl
module rbfd_dp
    import rbfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [7:0]        rx_byte,
    input  logic [BUF_AW-1:0] read_offset,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [BUF_AW-1:0] frame_start,
    output logic [LEN_W-1:0]  frame_length,
    output logic [7:0]        command_code,
    output logic [31:0]       declared_total,
    output logic [7:0]        sequence_number,
    output logic [7:0]        read_data,
    output logic              last
);

    logic [7:0] ring_mem [BUF_DEPTH];

    logic [7:0]        header_reg;
    logic [LEN_W-1:0]  max_len_reg;
    logic [7:0]        timeout_reg;
    logic [BUF_AW-1:0] wp_reg, rp_reg, lfs_reg, off_reg;
    logic              locked_reg, cmp0_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [7:0]        wait_reg, hi_reg, bcc_reg, rd_q;
    logic [NV_W-1:0]   n_reg;
    logic [2:0]        cur_status_reg;
    logic [7:0]        cur_cmd_reg, cur_seq_reg;
    logic [31:0]       cur_total_reg;
    verdict_t          held_reg;
    logic              held_v_reg;
    logic              out_valid_reg;
    verdict_t          out_v_reg;
    logic [7:0]        out_rd_reg;
    logic              out_last_reg;

    logic [BUF_AW-1:0] size, raddr;
    logic [16:0]       len_full;
    logic              out_free;

    assign size     = wp_reg - rp_reg;
    assign len_full = {1'b0, hi_reg, rd_q} + 17'(MIN_FRAME);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.rd_sel)
            RA_INPUT: raddr = lfs_reg + read_offset;
            RA_COUNT: raddr = rp_reg + off_reg;
            default:  raddr = rp_reg + cmd.rd_off;
        endcase
    end

    always_comb
    begin
        stat.full        = (size == {BUF_AW{1'b1}});
        stat.size_le10   = (size <= HUNT_MIN);
        stat.locked      = locked_reg;
        stat.complete    = ({1'b0, size} >= plen_reg);
        stat.wait_lt     = (wait_reg < timeout_reg);
        stat.hdr_match   = cmp0_reg && (rd_q == header_reg);
        stat.len_ok      = (len_full <= {6'b0, max_len_reg});
        stat.off_last    = ({1'b0, off_reg} == plen_reg - LEN_W'(1));
        stat.off_fld_end = (off_reg == BUF_AW'(7));
        stat.held_valid  = held_v_reg;
        stat.n_last      = (n_reg == NV_W'(MAX_VERDICTS - 1));
        stat.out_free    = out_free;
    end

    // ring memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE)
            ring_mem[wp_reg] <= rx_byte;
        if (cmd.rd_en)
            rd_q <= ring_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RST;
            max_len_reg   <= MAX_LEN_RST;
            timeout_reg   <= TIMEOUT_RST;
            wp_reg        <= '0;
            rp_reg        <= '0;
            lfs_reg       <= '0;
            locked_reg    <= 1'b0;
            plen_reg      <= '0;
            wait_reg      <= '0;
            n_reg         <= '0;
            held_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEADER:  header_reg  <= cfg_data[7:0];
                    REG_MAX_LEN: max_len_reg <= cfg_data;
                    REG_TIMEOUT: timeout_reg <= cfg_data[7:0];
                    default:     header_reg  <= header_reg;
                endcase
            end
            if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_WRITE:      wp_reg <= wp_reg + BUF_AW'(1);
                OP_LOAD_RD, OP_LOAD_OVF, OP_FLUSH:
                begin
                    out_valid_reg <= 1'b1;
                    if (cmd.op == OP_FLUSH)
                        held_v_reg <= 1'b0;
                end
                OP_TICK_START: n_reg <= '0;
                OP_SKIP1:      rp_reg <= rp_reg + BUF_AW'(1);
                OP_LOCK:
                begin
                    locked_reg <= 1'b1;
                    plen_reg   <= len_full[LEN_W-1:0];
                    wait_reg   <= '0;
                end
                OP_WAIT_INC:   wait_reg <= wait_reg + 8'd1;
                OP_BCC_START, OP_TIMEOUT: locked_reg <= 1'b0;
                OP_COMMIT:
                begin
                    if (held_v_reg)
                        out_valid_reg <= 1'b1;
                    held_v_reg <= 1'b1;
                    n_reg      <= n_reg + NV_W'(1);
                    if (cur_status_reg == ST_GOOD)
                    begin
                        lfs_reg <= rp_reg;
                        rp_reg  <= rp_reg + plen_reg[BUF_AW-1:0];
                    end
                    else
                        rp_reg <= rp_reg + BUF_AW'(1);
                end
                default:       n_reg <= n_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_HDR0:      cmp0_reg <= (rd_q == header_reg);
            OP_HI:        hi_reg   <= rd_q;
            OP_BCC_START:
            begin
                bcc_reg <= '0;
                off_reg <= BUF_AW'(2);
            end
            OP_BCC_ACC:
            begin
                bcc_reg <= bcc_reg ^ rd_q;
                off_reg <= off_reg + BUF_AW'(1);
            end
            OP_BCC_END:
            begin
                cur_status_reg <= (bcc_reg == rd_q) ? ST_GOOD : ST_BCC_ERR;
                off_reg        <= BUF_AW'(2);
            end
            OP_TIMEOUT:
            begin
                cur_status_reg <= ST_TIMEOUT;
                off_reg        <= BUF_AW'(2);
            end
            OP_FLD:
            begin
                off_reg <= off_reg + BUF_AW'(1);
                case (off_reg[2:0])
                    3'd2:    cur_cmd_reg          <= rd_q;
                    3'd3:    cur_total_reg[31:24] <= rd_q;
                    3'd4:    cur_total_reg[23:16] <= rd_q;
                    3'd5:    cur_total_reg[15:8]  <= rd_q;
                    3'd6:    cur_total_reg[7:0]   <= rd_q;
                    default: cur_seq_reg          <= rd_q;
                endcase
            end
            OP_COMMIT:
            begin
                held_reg <= '{cur_status_reg, rp_reg, plen_reg, cur_cmd_reg,
                              cur_total_reg, cur_seq_reg};
                if (held_v_reg)
                begin
                    out_v_reg    <= held_reg;
                    out_rd_reg   <= '0;
                    out_last_reg <= 1'b0;
                end
            end
            OP_FLUSH:
            begin
                out_v_reg    <= held_reg;
                out_rd_reg   <= '0;
                out_last_reg <= 1'b1;
            end
            OP_LOAD_RD:
            begin
                out_v_reg    <= '{ST_READ, lfs_reg, '0, '0, '0, '0};
                out_rd_reg   <= rd_q;
                out_last_reg <= 1'b1;
            end
            OP_LOAD_OVF:
            begin
                out_v_reg    <= '{ST_OVERFLOW, '0, '0, '0, '0, '0};
                out_rd_reg   <= '0;
                out_last_reg <= 1'b1;
            end
            default:      hi_reg <= hi_reg;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_v_reg.status;
    assign frame_start     = out_v_reg.start;
    assign frame_length    = out_v_reg.length;
    assign command_code    = out_v_reg.cmd;
    assign declared_total  = out_v_reg.total;
    assign sequence_number = out_v_reg.seq;
    assign read_data       = out_rd_reg;
    assign last            = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> (plen_reg >= MIN_FRAME))
        else $error("locked frame shorter than minimum");

    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NV_W'(MAX_VERDICTS))
        else $error("verdict count past cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WRITE) |-> !stat.full)
        else $error("byte stored into full ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COMMIT && held_v_reg) |-> out_free)
        else $error("output overwritten before taken");

endmodule

// File: rtl/core/ring_buffer_frame_deframer.sv
// top level of the length-prefixed frame deframer with xor block check
// depends on rbfd_pkg, rbfd_ctrl and rbfd_dp
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_ready    | req_type, rx_byte, read_offset
//  out     | out_valid / out_ready  | status, frame_start .. read_data, last
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// a byte request is stored from the idle state, an overflow or read request
// waits for a free output register; a tick skips bytes, locks on headers, checks
// frames byte by byte and pushes verdicts, with every ring byte read through the
// single ring read port
// no request is taken until the last verdict of a tick sits in the output register
// reset clears pointers, lock, counters and valid flags; ring data stays undefined
module ring_buffer_frame_deframer
    import rbfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [7:0]        rx_byte,
    input  logic [BUF_AW-1:0] read_offset,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [BUF_AW-1:0] frame_start,
    output logic [LEN_W-1:0]  frame_length,
    output logic [7:0]        command_code,
    output logic [31:0]       declared_total,
    output logic [7:0]        sequence_number,
    output logic [7:0]        read_data,
    output logic              last
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: hunts, locks, walks the check and pushes verdicts
    rbfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring store, pointers and result registers
    rbfd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .rx_byte         (rx_byte),
        .read_offset     (read_offset),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .frame_start     (frame_start),
        .frame_length    (frame_length),
        .command_code    (command_code),
        .declared_total  (declared_total),
        .sequence_number (sequence_number),
        .read_data       (read_data),
        .last            (last)
    );

endmodule

// File: test/testbench.sv
// testbench for ring_buffer_frame_deframer: random and directed requests, checked result by result
// depends on rbfd_pkg and the ring_buffer_frame_deframer rtl
module testbench
    import rbfd_pkg::*;
();

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         HOLD_LEN    = 600;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        req_type;
    logic [7:0]        rx_byte;
    logic [BUF_AW-1:0] read_offset;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [LEN_W-1:0]  cfg_data;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [BUF_AW-1:0] frame_start;
    logic [LEN_W-1:0]  frame_length;
    logic [7:0]        command_code;
    logic [31:0]       declared_total;
    logic [7:0]        sequence_number;
    logic [7:0]        read_data;
    logic              last;

    typedef struct packed {
        logic [2:0]        status;
        logic [BUF_AW-1:0] start;
        logic [LEN_W-1:0]  length;
        logic [7:0]        cmd;
        logic [31:0]       total;
        logic [7:0]        seq;
        logic [7:0]        data;
        logic              last;
    } frame_result_t;

    ring_buffer_frame_deframer u_top (.*);

    // shadow copy of the block state
    logic [7:0]        ring_mem [BUF_DEPTH];
    bit                ring_written [BUF_DEPTH];
    logic [BUF_AW-1:0] wr_ptr, rd_ptr, good_start;
    logic              locked;
    logic [LEN_W-1:0]  lock_len;
    logic [7:0]        wait_ticks;
    logic [7:0]        cfg_header;
    logic [LEN_W-1:0]  cfg_max_len;
    logic [7:0]        cfg_timeout;
    bit                good_seen;

    frame_result_t expected_results[$];
    int  error_count;
    int  items_sent;
    bit  hold_off;
    bit  stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int buffered();
        return int'(BUF_AW'(wr_ptr - rd_ptr));
    endfunction

    function automatic logic [7:0] peek(input int off);
        return ring_mem[BUF_AW'(rd_ptr + off)];
    endfunction

    function automatic frame_result_t verdict(input logic [2:0] st, input logic [LEN_W-1:0] len);
        frame_result_t r;
        r = '0;
        r.status = st;
        r.start  = rd_ptr;
        r.length = len;
        r.cmd    = peek(2);
        r.total  = {peek(3), peek(4), peek(5), peek(6)};
        r.seq    = peek(7);
        return r;
    endfunction

    // predict the results of one request and queue them
    task automatic predict_request(input logic [1:0] rq, input logic [7:0] b,
                                   input logic [BUF_AW-1:0] off);
        frame_result_t r;
        frame_result_t batch[$];
        int len;
        logic [7:0] x;
        r = '0;
        if (rq == REQ_BYTE)
        begin
            if (buffered() >= BUF_DEPTH - 1)
            begin
                r.status = ST_OVERFLOW;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            else
            begin
                ring_mem[wr_ptr] = b;
                ring_written[wr_ptr] = 1'b1;
                wr_ptr++;
            end
        end
        else if (rq == REQ_READ)
        begin
            r.status = ST_READ;
            r.start = good_start;
            r.data = ring_mem[BUF_AW'(good_start + off)];
            r.last = 1'b1;
            expected_results.push_back(r);
        end
        else if (rq == REQ_TICK)
        begin
            while (batch.size() < MAX_VERDICTS)
            begin
                if (!locked)
                begin
                    if (buffered() <= 10)
                        break;
                    if (peek(0) == cfg_header && peek(1) == cfg_header)
                    begin
                        len = {peek(8), peek(9)} + 11;
                        if (len <= cfg_max_len)
                        begin
                            locked = 1'b1;
                            lock_len = LEN_W'(len);
                            wait_ticks = 0;
                            continue;
                        end
                    end
                    rd_ptr++;
                end
                else if (buffered() >= lock_len)
                begin
                    locked = 1'b0;
                    x = 0;
                    for (int i = 2; i + 1 < lock_len; i++)
                        x ^= peek(i);
                    if (x == peek(lock_len - 1))
                    begin
                        batch.push_back(verdict(ST_GOOD, lock_len));
                        good_start = rd_ptr;
                        good_seen = 1'b1;
                        rd_ptr = BUF_AW'(rd_ptr + lock_len);
                    end
                    else
                    begin
                        batch.push_back(verdict(ST_BCC_ERR, lock_len));
                        rd_ptr++;
                    end
                end
                else if (wait_ticks < cfg_timeout)
                begin
                    wait_ticks++;
                    break;
                end
                else
                begin
                    locked = 1'b0;
                    batch.push_back(verdict(ST_TIMEOUT, lock_len));
                    rd_ptr++;
                end
            end
            if (batch.size() > 0)
                batch[batch.size()-1].last = 1'b1;
            foreach (batch[i])
                expected_results.push_back(batch[i]);
        end
    endtask

    // send one request, hold valid until accepted; valid stays up for a following request
    task automatic send_request(input logic [1:0] rq, input logic [7:0] b = 8'h00,
                                input logic [BUF_AW-1:0] off = '0);
        in_valid    <= 1'b1;
        req_type    <= rq;
        rx_byte     <= b;
        read_offset <= off;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(rq, b, off);
        items_sent++;
    endtask

    // sender gap between bursts
    int burst_left;
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_HEADER)
            cfg_header = val[7:0];
        else if (idx == REG_MAX_LEN)
            cfg_max_len = val;
        else
            cfg_timeout = val[7:0];
    endtask

    // wait until every expected result is out and the block is idle, plus settling time
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while ((expected_results.size() != 0 || !in_ready) && guard < 2000000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    // stream a well-formed frame, optionally with a corrupt check byte or truncated
    task automatic send_frame(input int payload, input bit corrupt, input int cut);
        logic [7:0] fr[$];
        logic [7:0] x;
        fr.push_back(cfg_header);
        fr.push_back(cfg_header);
        for (int i = 0; i < 6; i++)
            fr.push_back(8'($urandom));
        fr.push_back(8'(payload >> 8));
        fr.push_back(8'(payload));
        for (int i = 0; i < payload; i++)
            fr.push_back(8'($urandom));
        x = 0;
        for (int i = 2; i < fr.size(); i++)
            x ^= fr[i];
        fr.push_back(corrupt ? ~x : x);
        for (int i = 0; i < fr.size() - cut; i++)
        begin
            pace();
            send_request(REQ_BYTE, fr[i]);
        end
    endtask

    // reads only land on written entries
    task automatic read_back();
        logic [BUF_AW-1:0] off;
        off = BUF_AW'($urandom);
        if (!ring_written[BUF_AW'(good_start + off)])
            off = 0;
        if (ring_written[BUF_AW'(good_start + off)])
            send_request(REQ_READ, 8'h00, off);
    endtask

    task automatic test_directed();
        send_request(REQ_TICK);
        send_frame(0, 1'b0, 0);
        send_request(REQ_TICK);
        read_back();
        send_request(REQ_READ, 8'h00, BUF_AW'(10));
        send_frame(3, 1'b1, 0);
        send_request(REQ_TICK);
        send_request(REQ_UNKNOWN, 8'hff, '1);
        send_request(REQ_BYTE, 8'hff);
        send_request(REQ_BYTE, 8'h00);
        send_request(REQ_TICK);
        drain();
        // zero timeout with a truncated frame
        write_reg(REG_TIMEOUT, 8'd0);
        send_frame(4, 1'b0, 3);
        send_request(REQ_TICK);
        send_request(REQ_TICK);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_MAX_LEN, LEN_W'(10));
        write_reg(REG_HEADER, 8'hff);
        send_frame(1, 1'b0, 0);
        send_request(REQ_TICK);
        drain();
        write_reg(REG_MAX_LEN, LEN_W'(11));
        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_TIMEOUT, 8'd255);
        send_frame(0, 1'b0, 0);
        send_frame(2, 1'b0, 0);
        send_request(REQ_TICK);
        drain();
        write_reg(REG_MAX_LEN, LEN_W'(1024));
        write_reg(REG_TIMEOUT, 8'd3);
        write_reg(REG_HEADER, 8'h5a);
        // oversize length that fits the limit but never completes
        send_frame(1013, 1'b0, 1013);
        repeat (6) send_request(REQ_TICK);
        drain();
    endtask

    task automatic test_random(input int items);
        int start, pick;
        start = items_sent;
        while (items_sent - start < items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                send_frame($urandom_range(0, 5) == 0 ? $urandom_range(0, 60) :
                           $urandom_range(0, 8), $urandom_range(0, 4) == 0,
                           $urandom_range(0, 6) == 0 ? $urandom_range(1, 4) : 0);
            end
            else if (pick < 8)
            begin
                pace();
                send_request(REQ_BYTE, 8'($urandom));
            end
            else
            begin
                pace();
                if ($urandom_range(0, 1))
                    read_back();
                else
                    send_request(REQ_UNKNOWN, 8'($urandom), BUF_AW'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
                send_request(REQ_TICK);
        end
        send_request(REQ_TICK);
        send_request(REQ_TICK);
        drain();
    endtask

    // hold the receiver off while verdicts and reads pile up and stall the input
    task automatic test_backpressure();
        write_reg(REG_HEADER, 8'h23);
        write_reg(REG_TIMEOUT, 8'd100);
        hold_off = 1'b1;
        for (int i = 0; i < 3; i++)
            send_frame(i, 1'b0, 0);
        send_request(REQ_TICK);
        repeat (4) read_back();
        hold_off = 1'b0;
        drain();
    endtask

    // receiver stall pattern; a hold-off keeps out_ready low, random stalls follow when enabled
    int hold_cycles;
    always @(posedge clk)
    begin
        if (hold_off && hold_cycles < HOLD_LEN)
        begin
            hold_cycles <= hold_cycles + 1;
            out_ready <= 1'b0;
        end
        else if (!stall_enable)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        frame_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result status", status, 0);
            else
            begin
                w = expected_results.pop_front();
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (frame_start !== w.start) report_mismatch("frame_start", frame_start, w.start);
                if (frame_length !== w.length)
                    report_mismatch("frame_length", frame_length, w.length);
                if (command_code !== w.cmd) report_mismatch("command_code", command_code, w.cmd);
                if (declared_total !== w.total)
                    report_mismatch("declared_total", declared_total, w.total);
                if (sequence_number !== w.seq)
                    report_mismatch("sequence_number", sequence_number, w.seq);
                if (read_data !== w.data) report_mismatch("read_data", read_data, w.data);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_BYTE;
        rx_byte = '0;
        read_offset = '0;
        cfg_we = 1'b0;
        cfg_index = REG_HEADER;
        cfg_data = '0;
        out_ready = 1'b1;
        hold_off = 1'b0;
        hold_cycles = 0;
        stall_enable = 1'b0;
        burst_left = 0;
        error_count = 0;
        items_sent = 0;
        wr_ptr = 0;
        rd_ptr = 0;
        good_start = 0;
        good_seen = 1'b0;
        locked = 1'b0;
        lock_len = 0;
        wait_ticks = 0;
        cfg_header = HEADER_RST;
        cfg_max_len = MAX_LEN_RST;
        cfg_timeout = TIMEOUT_RST;
        foreach (ring_mem[i])
        begin
            ring_mem[i] = 0;
            ring_written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_enable = 1'b1;
        test_config_extremes();
        test_random(130);
        stall_enable = 1'b0;
        test_random(40);
        stall_enable = 1'b1;
        test_backpressure();
        test_random(70);
        drain();
        if (expected_results.size() != 0)
            report_mismatch("missing results", expected_results.size(), 0);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
